### rtl/tpba_pkg.sv
// Package for the two-pool bitmap slot allocator.
// Holds pool sizes, command codes and the request, result and bitmap types.
// No dependencies; every other file of the block uses it by scoped name.
package tpba_pkg;

   // Pool geometry.
   localparam int SMALL_SLOTS = 8;
   localparam int LARGE_SLOTS = 8;
   localparam int SMALL_BYTES = 16;
   localparam int LARGE_BYTES = 32;

   // Field widths.
   localparam int MAP_W    = 8;
   localparam int IDX_W    = 3;
   localparam int HANDLE_W = 4;
   localparam int OFFSET_W = 9;

   // Large slots follow the small ones in the shared storage.
   localparam int LARGE_BASE = SMALL_SLOTS * SMALL_BYTES;

   // Bits that belong to each pool.
   localparam logic [MAP_W-1:0] SMALL_MASK = MAP_W'((1 << SMALL_SLOTS) - 1);
   localparam logic [MAP_W-1:0] LARGE_MASK = MAP_W'((1 << LARGE_SLOTS) - 1);

   // Command and size class codes.
   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_FREE    = 1'b1;
   localparam logic CLASS_SMALL = 1'b0;
   localparam logic CLASS_LARGE = 1'b1;

   typedef struct packed {
      logic                cmd;
      logic                size_class;
      logic [HANDLE_W-1:0] handle_in;
   } req_type;

   typedef struct packed {
      logic                granted;
      logic [HANDLE_W-1:0] handle_out;
      logic [OFFSET_W-1:0] byte_offset;
      logic [MAP_W-1:0]    small_map;
      logic [MAP_W-1:0]    large_map;
   } rsp_type;

   typedef struct packed {
      logic [MAP_W-1:0] small_map;
      logic [MAP_W-1:0] large_map;
   } maps_type;

endpackage

### rtl/tpba_decide.sv
// Combinational allocate/free decision for the two-pool slot allocator.
// Finds free slots, builds the result and the next occupancy bitmaps.
// Depends on tpba_pkg.
module tpba_decide (
   input  tpba_pkg::req_type  item,
   input  tpba_pkg::maps_type maps_cur,
   output tpba_pkg::maps_type maps_nxt,
   output tpba_pkg::rsp_type  result
);

   logic                          small_found;
   logic [tpba_pkg::IDX_W-1:0]    small_idx;
   logic                          large_found;
   logic [tpba_pkg::IDX_W-1:0]    large_idx;
   logic                          pair_found;
   logic [tpba_pkg::IDX_W-1:0]    pair_idx;
   logic [tpba_pkg::IDX_W-1:0]    free_idx;
   logic                          free_fb;
   logic [tpba_pkg::MAP_W-1:0]    sm;
   logic [tpba_pkg::MAP_W-1:0]    lg;

   // Lowest free single slot in each pool; scan from the top so the lowest wins.
   always_comb begin
      small_found = 1'b0;
      small_idx   = '0;
      large_found = 1'b0;
      large_idx   = '0;
      for (int i = tpba_pkg::MAP_W - 1; i >= 0; i--) begin
         if (i < tpba_pkg::SMALL_SLOTS && !maps_cur.small_map[i]) begin
            small_found = 1'b1;
            small_idx   = tpba_pkg::IDX_W'(i);
         end
         if (i < tpba_pkg::LARGE_SLOTS && !maps_cur.large_map[i]) begin
            large_found = 1'b1;
            large_idx   = tpba_pkg::IDX_W'(i);
         end
      end
   end

   // Lowest pair of adjacent free small slots.
   always_comb begin
      pair_found = 1'b0;
      pair_idx   = '0;
      for (int i = tpba_pkg::MAP_W - 2; i >= 0; i--) begin
         if (i + 1 < tpba_pkg::SMALL_SLOTS && maps_cur.small_map[i+1 -: 2] == 2'b00) begin
            pair_found = 1'b1;
            pair_idx   = tpba_pkg::IDX_W'(i);
         end
      end
   end

   assign free_fb  = item.handle_in[tpba_pkg::HANDLE_W-1];
   assign free_idx = item.handle_in[tpba_pkg::IDX_W-1:0];

   // Decision and bitmap update.
   always_comb begin
      sm                 = maps_cur.small_map;
      lg                 = maps_cur.large_map;
      result.granted     = 1'b0;
      result.handle_out  = '0;
      result.byte_offset = '0;
      if (item.cmd == tpba_pkg::CMD_ALLOC) begin
         if (item.size_class == tpba_pkg::CLASS_SMALL) begin
            if (small_found) begin
               sm                 = sm | (tpba_pkg::MAP_W'(1) << small_idx);
               result.granted     = 1'b1;
               result.handle_out  = {1'b0, small_idx};
               result.byte_offset = tpba_pkg::OFFSET_W'(tpba_pkg::SMALL_BYTES * small_idx);
            end else if (large_found) begin
               lg                 = lg | (tpba_pkg::MAP_W'(1) << large_idx);
               result.granted     = 1'b1;
               result.handle_out  = {1'b1, large_idx};
               result.byte_offset = tpba_pkg::OFFSET_W'(tpba_pkg::LARGE_BASE
                                    + tpba_pkg::LARGE_BYTES * large_idx);
            end
         end else begin
            if (large_found) begin
               lg                 = lg | (tpba_pkg::MAP_W'(1) << large_idx);
               result.granted     = 1'b1;
               result.handle_out  = {1'b0, large_idx};
               result.byte_offset = tpba_pkg::OFFSET_W'(tpba_pkg::LARGE_BASE
                                    + tpba_pkg::LARGE_BYTES * large_idx);
            end else if (pair_found) begin
               sm                 = sm | (tpba_pkg::MAP_W'(3) << pair_idx);
               result.granted     = 1'b1;
               result.handle_out  = {1'b1, pair_idx};
               result.byte_offset = tpba_pkg::OFFSET_W'(tpba_pkg::SMALL_BYTES * pair_idx);
            end
         end
      end else begin
         // A free echoes the handle and clears the named bits if they are in range.
         result.handle_out = item.handle_in;
         if (item.size_class == tpba_pkg::CLASS_SMALL) begin
            if (free_fb) begin
               if (int'(free_idx) < tpba_pkg::LARGE_SLOTS) begin
                  lg             = lg & ~(tpba_pkg::MAP_W'(1) << free_idx);
                  result.granted = 1'b1;
               end
            end else if (int'(free_idx) < tpba_pkg::SMALL_SLOTS) begin
               sm             = sm & ~(tpba_pkg::MAP_W'(1) << free_idx);
               result.granted = 1'b1;
            end
         end else begin
            if (free_fb) begin
               if (int'(free_idx) + 1 < tpba_pkg::SMALL_SLOTS) begin
                  sm             = sm & ~(tpba_pkg::MAP_W'(3) << free_idx);
                  result.granted = 1'b1;
               end
            end else if (int'(free_idx) < tpba_pkg::LARGE_SLOTS) begin
               lg             = lg & ~(tpba_pkg::MAP_W'(1) << free_idx);
               result.granted = 1'b1;
            end
         end
      end
      maps_nxt.small_map = sm & tpba_pkg::SMALL_MASK;
      maps_nxt.large_map = lg & tpba_pkg::LARGE_MASK;
      result.small_map   = maps_nxt.small_map;
      result.large_map   = maps_nxt.large_map;
   end

endmodule

### rtl/two_pool_bitmap_allocator_top.sv
// Top level of the two-pool bitmap slot allocator.
// Input register, decision logic (tpba_decide), result register and bitmaps.
// Depends on tpba_pkg and tpba_decide.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | tpba_pkg::req_type
//   rsp     | out       | rsp_valid / rsp_ready | tpba_pkg::rsp_type
//
// Each request is registered, decided combinationally and its result registered,
// so its result is offered once the result register is free or being drained.
// One request every cycle if results drain; bitmap registers close the only loop.
// Synchronous reset clears both bitmaps (every slot free) and both stages.
// A stalled result holds the input stage, which then drops req_ready.
module two_pool_bitmap_allocator_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tpba_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tpba_pkg::rsp_type rsp_data
);

   logic               stage_valid_ff;
   logic               stage_valid_in;
   tpba_pkg::req_type  stage_item_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   tpba_pkg::rsp_type  rsp_data_ff;
   tpba_pkg::maps_type maps_ff;
   tpba_pkg::maps_type maps_in;
   tpba_pkg::rsp_type  decided;
   logic               load_result;

   // Decision for the item in the input stage.
   tpba_decide u_decide (
      .item     (stage_item_ff),
      .maps_cur (maps_ff),
      .maps_nxt (maps_in),
      .result   (decided)
   );

   // The input stage moves on when the result register is free or being drained.
   assign load_result    = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready      = !stage_valid_ff || load_result;
   assign stage_valid_in = req_valid || (stage_valid_ff && !load_result);
   assign rsp_valid_in   = load_result || (rsp_valid_ff && !rsp_ready);

   // Control state and bitmaps.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         maps_ff        <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (load_result) begin
            maps_ff <= maps_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_item_ff <= req_data;
      end
      if (load_result) begin
         rsp_data_ff <= decided;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Bits beyond each pool are never set.
   a_pool_bounds: assert property (@(posedge clock) disable iff (reset)
      ((maps_ff.small_map & ~tpba_pkg::SMALL_MASK) == '0) &&
      ((maps_ff.large_map & ~tpba_pkg::LARGE_MASK) == '0))
      else $error("occupancy bit set outside its pool");

   // The bitmaps change only when a result transfer into the output register happens.
   a_maps_hold: assert property (@(posedge clock) disable iff (reset)
      !load_result |=> $stable(maps_ff))
      else $error("bitmaps changed without a decided item");

   // A waiting result reports the bitmaps as they stand.
   a_maps_reported: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.small_map == maps_ff.small_map &&
                        rsp_data_ff.large_map == maps_ff.large_map))
      else $error("reported bitmaps differ from the occupancy state");

   // A refused request or any free reports a zero offset.
   a_zero_offset: assert property (@(posedge clock) disable iff (reset)
      load_result && (!decided.granted || stage_item_ff.cmd == tpba_pkg::CMD_FREE)
      |=> rsp_data_ff.byte_offset == '0)
      else $error("nonzero offset without an allocation");

endmodule

### verif/two_pool_bitmap_allocator_top_test.sv
// Testbench for two_pool_bitmap_allocator_top: directed opening script, then random traffic.
// Results are checked against an in-bench shadow of both slot bitmaps.
// Depends on tpba_pkg and the allocator RTL.
`timescale 1ns / 1ps

module two_pool_bitmap_allocator_top_test;

   localparam int FALLBACK_BASE  = 8;
   localparam int RANDOM_ITEMS   = 1700;
   localparam int SQUEEZE_START  = 500;
   localparam int SQUEEZE_ITEMS  = 60;
   localparam int SQUEEZE_CYCLES = 80;
   localparam int DRAIN_PAUSE_AT = 1100;
   localparam int SETTLE_CYCLES  = 12;
   localparam int CYCLE_LIMIT    = 400000;

   typedef struct {
      tpba_pkg::req_type req;
      bit                typed;
      tpba_pkg::rsp_type want;
   } script_row;

   typedef struct {
      logic                          size_class;
      logic [tpba_pkg::HANDLE_W-1:0] handle;
   } live_slot;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   tpba_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   tpba_pkg::rsp_type rsp_data;

   logic [tpba_pkg::MAP_W-1:0] shadow_small_map;
   logic [tpba_pkg::MAP_W-1:0] shadow_large_map;
   tpba_pkg::rsp_type          pending_grants[$];
   live_slot                   live_slots[$];
   script_row                  opening_script[$];
   int                         mismatch_count;
   int                         cycle_count;
   bit                         squeeze_request;

   two_pool_bitmap_allocator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Free-running clock, 12 ns period.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Global cycle limit; a hung handshake ends the run here.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Lowest clear bit below the pool size, or -1 when the pool is full.
   function automatic int lowest_free_slot(logic [tpba_pkg::MAP_W-1:0] map, int slots);
      for (int i = 0; i < slots && i < tpba_pkg::MAP_W; i++) begin
         if (!map[i]) return i;
      end
      return -1;
   endfunction

   // Computes the result of one request and advances the shadow bitmaps.
   function automatic tpba_pkg::rsp_type predict_grant(tpba_pkg::req_type r);
      tpba_pkg::rsp_type          o;
      logic [tpba_pkg::MAP_W-1:0] sm;
      logic [tpba_pkg::MAP_W-1:0] lg;
      int                         idx;
      int                         off;
      bit                         fallback;
      o = '0;
      off = 0;
      sm = shadow_small_map;
      lg = shadow_large_map;
      if (r.cmd == tpba_pkg::CMD_ALLOC) begin
         if (r.size_class == tpba_pkg::CLASS_SMALL) begin
            idx = lowest_free_slot(sm, tpba_pkg::SMALL_SLOTS);
            if (idx >= 0) begin
               sm[idx] = 1'b1;
               o.granted = 1'b1;
               o.handle_out = tpba_pkg::HANDLE_W'(idx);
               off = tpba_pkg::SMALL_BYTES * idx;
            end else begin
               // Small pool full: borrow a large slot.
               idx = lowest_free_slot(lg, tpba_pkg::LARGE_SLOTS);
               if (idx >= 0) begin
                  lg[idx] = 1'b1;
                  o.granted = 1'b1;
                  o.handle_out = tpba_pkg::HANDLE_W'(idx + FALLBACK_BASE);
                  off = tpba_pkg::LARGE_BASE + tpba_pkg::LARGE_BYTES * idx;
               end
            end
         end else begin
            idx = lowest_free_slot(lg, tpba_pkg::LARGE_SLOTS);
            if (idx >= 0) begin
               lg[idx] = 1'b1;
               o.granted = 1'b1;
               o.handle_out = tpba_pkg::HANDLE_W'(idx);
               off = tpba_pkg::LARGE_BASE + tpba_pkg::LARGE_BYTES * idx;
            end else begin
               // Large pool full: take the lowest pair of adjacent free small slots.
               idx = -1;
               for (int i = tpba_pkg::SMALL_SLOTS - 2; i >= 0; i--) begin
                  if (i < tpba_pkg::MAP_W - 1 && !sm[i] && !sm[i+1]) idx = i;
               end
               if (idx >= 0) begin
                  sm[idx] = 1'b1;
                  sm[idx+1] = 1'b1;
                  o.granted = 1'b1;
                  o.handle_out = tpba_pkg::HANDLE_W'(idx + FALLBACK_BASE);
                  off = tpba_pkg::SMALL_BYTES * idx;
               end
            end
         end
      end else begin
         // A free echoes the handle; an index outside its pool clears nothing.
         fallback = (r.handle_in >= FALLBACK_BASE);
         idx = int'(r.handle_in[tpba_pkg::IDX_W-1:0]);
         o.handle_out = r.handle_in;
         if (r.size_class == tpba_pkg::CLASS_SMALL) begin
            if (fallback) begin
               if (idx < tpba_pkg::LARGE_SLOTS) begin
                  lg[idx] = 1'b0;
                  o.granted = 1'b1;
               end
            end else if (idx < tpba_pkg::SMALL_SLOTS) begin
               sm[idx] = 1'b0;
               o.granted = 1'b1;
            end
         end else begin
            if (fallback) begin
               if (idx + 1 < tpba_pkg::SMALL_SLOTS) begin
                  sm[idx] = 1'b0;
                  sm[idx+1] = 1'b0;
                  o.granted = 1'b1;
               end
            end else if (idx < tpba_pkg::LARGE_SLOTS) begin
               lg[idx] = 1'b0;
               o.granted = 1'b1;
            end
         end
      end
      sm &= tpba_pkg::SMALL_MASK;
      lg &= tpba_pkg::LARGE_MASK;
      shadow_small_map = sm;
      shadow_large_map = lg;
      o.byte_offset = tpba_pkg::OFFSET_W'(off);
      o.small_map = sm;
      o.large_map = lg;
      return o;
   endfunction

   // Gap length for one side: none, mostly short, now and then long.
   function automatic int pick_gap(int mode);
      int roll;
      roll = $urandom_range(0, 99);
      if (mode == 0) return 0;
      if (mode == 1) begin
         if (roll < 70) return 0;
         if (roll < 93) return $urandom_range(1, 3);
         return $urandom_range(6, 20);
      end
      if (roll < 40) return 0;
      if (roll < 85) return $urandom_range(1, 4);
      return $urandom_range(10, 30);
   endfunction

   function automatic script_row mk_row(logic cmd, logic cls,
                                        logic [tpba_pkg::HANDLE_W-1:0] h,
                                        bit typed, tpba_pkg::rsp_type want);
      script_row row;
      row.req = '{cmd: cmd, size_class: cls, handle_in: h};
      row.typed = typed;
      row.want = want;
      return row;
   endfunction

   // Random request: mostly allocations and frees of live handles, some noise.
   // The allocation share swings between fill and drain phases.
   function automatic tpba_pkg::req_type draw_request(int n);
      tpba_pkg::req_type r;
      int                alloc_pct;
      int                k;
      alloc_pct = ((n / 64) % 2 == 0) ? 75 : 30;
      if ($urandom_range(0, 99) < 12) begin
         r = tpba_pkg::req_type'($bits(tpba_pkg::req_type)'($urandom));
      end else if ($urandom_range(0, 99) < alloc_pct) begin
         r.cmd = tpba_pkg::CMD_ALLOC;
         r.size_class = ($urandom_range(0, 1) == 0) ? tpba_pkg::CLASS_SMALL
                                                     : tpba_pkg::CLASS_LARGE;
         r.handle_in = tpba_pkg::HANDLE_W'($urandom);
      end else if (live_slots.size() != 0) begin
         k = $urandom_range(0, live_slots.size() - 1);
         r.cmd = tpba_pkg::CMD_FREE;
         r.size_class = live_slots[k].size_class;
         r.handle_in = live_slots[k].handle;
         live_slots.delete(k);
      end else begin
         r.cmd = tpba_pkg::CMD_FREE;
         r.size_class = ($urandom_range(0, 1) == 0) ? tpba_pkg::CLASS_SMALL
                                                     : tpba_pkg::CLASS_LARGE;
         r.handle_in = tpba_pkg::HANDLE_W'($urandom);
      end
      return r;
   endfunction

   // Offers one request after an optional gap and returns once it transfers.
   task automatic offer_request(tpba_pkg::req_type r, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Books the expected result of a transferred request and tracks live handles.
   task automatic book_transfer(tpba_pkg::req_type r, bit typed, tpba_pkg::rsp_type want);
      tpba_pkg::rsp_type predicted;
      live_slot          slot;
      predicted = predict_grant(r);
      pending_grants.push_back(typed ? want : predicted);
      if (r.cmd == tpba_pkg::CMD_ALLOC && predicted.granted) begin
         slot.size_class = r.size_class;
         slot.handle = predicted.handle_out;
         live_slots.push_back(slot);
      end
   endtask

   // Compares one result with the oldest expectation, field by field.
   task automatic check_result(tpba_pkg::rsp_type got);
      tpba_pkg::rsp_type want;
      if (pending_grants.size() == 0) begin
         $display("%0t: unexpected result %h", $time, got);
         mismatch_count++;
      end else begin
         want = pending_grants.pop_front();
         if (got.granted !== want.granted) begin
            $display("%0t: granted expected %0d actual %0d", $time, want.granted, got.granted);
            mismatch_count++;
         end
         if (got.handle_out !== want.handle_out) begin
            $display("%0t: handle_out expected %0d actual %0d", $time,
                     want.handle_out, got.handle_out);
            mismatch_count++;
         end
         if (got.byte_offset !== want.byte_offset) begin
            $display("%0t: byte_offset expected %0d actual %0d", $time,
                     want.byte_offset, got.byte_offset);
            mismatch_count++;
         end
         if (got.small_map !== want.small_map) begin
            $display("%0t: small_map expected %h actual %h", $time,
                     want.small_map, got.small_map);
            mismatch_count++;
         end
         if (got.large_map !== want.large_map) begin
            $display("%0t: large_map expected %h actual %h", $time,
                     want.large_map, got.large_map);
            mismatch_count++;
         end
      end
   endtask

   // Result side: checks each transfer and stalls at random, with a long hold on request.
   initial begin
      int hold;
      int mode;
      int tick;
      rsp_ready = 1'b0;
      hold = 0;
      mode = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (squeeze_request) begin
            squeeze_request = 1'b0;
            hold = SQUEEZE_CYCLES;
         end
         if (hold == 0) hold = pick_gap(mode);
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
         tick++;
         if (tick % 256 == 0) mode = $urandom_range(0, 2);
      end
   end

   // Request side: reset, opening script, random traffic, then drain and verdict.
   initial begin
      int                src_mode;
      int                gap;
      tpba_pkg::req_type r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      mismatch_count = 0;
      squeeze_request = 1'b0;
      shadow_small_map = '0;
      shadow_large_map = '0;
      src_mode = 1;

      // Opening script: first grants, free errors, pool exhaustion and both fallbacks.
      opening_script.push_back(mk_row(tpba_pkg::CMD_ALLOC, tpba_pkg::CLASS_SMALL, 4'd0, 1,
                               tpba_pkg::rsp_type'{1'b1, 4'd0, 9'd0, 8'h01, 8'h00}));
      opening_script.push_back(mk_row(tpba_pkg::CMD_ALLOC, tpba_pkg::CLASS_LARGE, 4'd15, 1,
                               tpba_pkg::rsp_type'{1'b1, 4'd0, 9'd128, 8'h01, 8'h01}));
      opening_script.push_back(mk_row(tpba_pkg::CMD_FREE, tpba_pkg::CLASS_SMALL, 4'd15, 0,
                                      '0));
      opening_script.push_back(mk_row(tpba_pkg::CMD_FREE, tpba_pkg::CLASS_LARGE, 4'd15, 1,
                               tpba_pkg::rsp_type'{1'b0, 4'd15, 9'd0, 8'h01, 8'h01}));
      opening_script.push_back(mk_row(tpba_pkg::CMD_FREE, tpba_pkg::CLASS_LARGE, 4'd14, 0,
                                      '0));
      for (int i = 1; i < tpba_pkg::SMALL_SLOTS; i++) begin
         opening_script.push_back(mk_row(tpba_pkg::CMD_ALLOC, tpba_pkg::CLASS_SMALL,
                                         tpba_pkg::HANDLE_W'(i + 7), 0, '0));
      end
      opening_script.push_back(mk_row(tpba_pkg::CMD_ALLOC, tpba_pkg::CLASS_SMALL, 4'd5, 0,
                                      '0));
      for (int i = 2; i < tpba_pkg::LARGE_SLOTS; i++) begin
         opening_script.push_back(mk_row(tpba_pkg::CMD_ALLOC, tpba_pkg::CLASS_LARGE, 4'd0, 0,
                                         '0));
      end
      opening_script.push_back(mk_row(tpba_pkg::CMD_ALLOC, tpba_pkg::CLASS_LARGE, 4'd0, 1,
                               tpba_pkg::rsp_type'{1'b0, 4'd0, 9'd0, 8'hFF, 8'hFF}));
      opening_script.push_back(mk_row(tpba_pkg::CMD_ALLOC, tpba_pkg::CLASS_SMALL, 4'd9, 1,
                               tpba_pkg::rsp_type'{1'b0, 4'd0, 9'd0, 8'hFF, 8'hFF}));
      opening_script.push_back(mk_row(tpba_pkg::CMD_FREE, tpba_pkg::CLASS_SMALL, 4'd3, 0,
                                      '0));
      opening_script.push_back(mk_row(tpba_pkg::CMD_FREE, tpba_pkg::CLASS_SMALL, 4'd4, 0,
                                      '0));
      opening_script.push_back(mk_row(tpba_pkg::CMD_ALLOC, tpba_pkg::CLASS_LARGE, 4'd0, 0,
                                      '0));
      opening_script.push_back(mk_row(tpba_pkg::CMD_FREE, tpba_pkg::CLASS_LARGE, 4'd0, 0,
                                      '0));
      opening_script.push_back(mk_row(tpba_pkg::CMD_FREE, tpba_pkg::CLASS_LARGE, 4'd11, 0,
                                      '0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_script[i]) begin
         offer_request(opening_script[i].req, pick_gap(src_mode));
         book_transfer(opening_script[i].req, opening_script[i].typed, opening_script[i].want);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) src_mode = $urandom_range(0, 2);
         // Hold the result side off while requests keep coming, so the pipe backs up.
         if (n == SQUEEZE_START) squeeze_request = 1'b1;
         // Let every outstanding result come home before going on.
         if (n == DRAIN_PAUSE_AT) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_grants.size() != 0);
         end
         gap = (n >= SQUEEZE_START && n < SQUEEZE_START + SQUEEZE_ITEMS) ? 0
                                                                        : pick_gap(src_mode);
         r = draw_request(n);
         offer_request(r, gap);
         book_transfer(r, 0, '0);
      end

      // Drain, then give any stray result time to show up.
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_grants.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### two_pool_bitmap_allocator_top.f
rtl/tpba_pkg.sv
rtl/tpba_decide.sv
rtl/two_pool_bitmap_allocator_top.sv
verif/two_pool_bitmap_allocator_top_test.sv
